@@ hdl/rhc_pkg.sv @@
// ============================================================================
// RGB to HSV converter package
// Shared constants, the hue sextant code and the side information that
// travels with a pixel through the divider pipeline.
// ============================================================================
package rhc_pkg;

  // Default parameter values of the converter.
  localparam int CHANNEL_BITS_DEF  = 8;
  localparam int HUE_FRAC_BITS_DEF = 6;

  // Fixed widths of the result fields.
  localparam int HUE_W = 15;
  localparam int SAT_W = 16;

  // Hue geometry in whole degrees.
  localparam int SEXTANT_DEG    = 60;
  localparam int GREEN_BASE_DEG = 2 * SEXTANT_DEG;
  localparam int BLUE_BASE_DEG  = 4 * SEXTANT_DEG;
  localparam int FULL_DEG       = 360;

  // Channel that holds the maximum, which picks the hue sextant.
  typedef enum logic [1:0] {
    SEL_RED   = 2'd0,
    SEL_GREEN = 2'd1,
    SEL_BLUE  = 2'd2
  } hue_sel_t;

  // Per-pixel information that is needed after the divisions.
  typedef struct packed {
    hue_sel_t sel;
    logic     neg;
    logic     gray;
  } hue_side_t;

endpackage

@@ hdl/rhc_if.sv @@
// ============================================================================
// RGB to HSV stream interfaces
// Valid/ready channels for the pixel input and for the HSV result.
// ============================================================================
interface rhc_pixel_if #(
  parameter int CHANNEL_BITS = rhc_pkg::CHANNEL_BITS_DEF
) ();
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red_in;
  logic [CHANNEL_BITS-1:0] green_in;
  logic [CHANNEL_BITS-1:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in, input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

interface rhc_hsv_if #(
  parameter int CHANNEL_BITS = rhc_pkg::CHANNEL_BITS_DEF
) ();
  logic                     valid;
  logic                     ready;
  logic [rhc_pkg::HUE_W-1:0] hue_out;
  logic [rhc_pkg::SAT_W-1:0] sat_out;
  logic [CHANNEL_BITS-1:0]   value_out;

  modport source (output valid, output hue_out, output sat_out, output value_out, input ready);
  modport sink   (input valid, input hue_out, input sat_out, input value_out, output ready);
endinterface

@@ hdl/rhc_front.sv @@
// ============================================================================
// RGB to HSV front end
// Three register stages: max/min search, delta and hue difference, then the
// two dividends of the saturation and hue divisions.
// ============================================================================
module rhc_front #(
  parameter int CHANNEL_BITS      = rhc_pkg::CHANNEL_BITS_DEF,
  parameter int HUE_FRACTION_BITS = rhc_pkg::HUE_FRAC_BITS_DEF,
  parameter int DIV_STEPS         = rhc_pkg::SAT_W
) (
  input  logic                              clk,
  input  logic [2:0]                        ld,
  input  logic [CHANNEL_BITS-1:0]           red,
  input  logic [CHANNEL_BITS-1:0]           green,
  input  logic [CHANNEL_BITS-1:0]           blue,
  output logic [CHANNEL_BITS+DIV_STEPS-1:0] num_sat,
  output logic [CHANNEL_BITS-1:0]           den_sat,
  output logic [CHANNEL_BITS+DIV_STEPS-1:0] num_hue,
  output logic [CHANNEL_BITS-1:0]           den_hue,
  output rhc_pkg::hue_side_t                side
);
  import rhc_pkg::*;

  localparam int CB = CHANNEL_BITS;
  localparam int W  = CHANNEL_BITS + DIV_STEPS;
  localparam logic [W-1:0] HUE_MUL = W'(SEXTANT_DEG) << HUE_FRACTION_BITS;

  // Stage 1 signals.
  logic [CB-1:0] mx_rg, mn_rg;
  logic [CB-1:0] mx1_nxt, mn1_nxt, opa1_nxt, opb1_nxt;
  hue_sel_t      sel1_nxt;
  logic [CB-1:0] mx1_r, mn1_r, opa1_r, opb1_r;
  hue_sel_t      sel1_r;

  // Stage 2 signals.
  logic [CB-1:0] delta2_nxt, mag2_nxt;
  logic          neg2_nxt;
  logic [CB-1:0] delta2_r, mag2_r, mx2_r;
  logic          neg2_r;
  hue_sel_t      sel2_r;

  // Stage 3 signals.
  logic [W-1:0]  num_sat_nxt, num_hue_nxt;
  hue_side_t     side_nxt;
  logic [W-1:0]  num_sat_r, num_hue_r;
  logic [CB-1:0] den_sat_r, den_hue_r;
  hue_side_t     side_r;

  // Largest and smallest channel; the first channel equal to the maximum wins.
  always_comb begin
    mx_rg    = (red > green) ? red : green;
    mn_rg    = (red < green) ? red : green;
    mx1_nxt  = (mx_rg > blue) ? mx_rg : blue;
    mn1_nxt  = (mn_rg < blue) ? mn_rg : blue;
    if (red == mx1_nxt) begin
      sel1_nxt = SEL_RED;
      opa1_nxt = green;
      opb1_nxt = blue;
    end else if (green == mx1_nxt) begin
      sel1_nxt = SEL_GREEN;
      opa1_nxt = blue;
      opb1_nxt = red;
    end else begin
      sel1_nxt = SEL_BLUE;
      opa1_nxt = red;
      opb1_nxt = green;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      mx1_r  <= mx1_nxt;
      mn1_r  <= mn1_nxt;
      opa1_r <= opa1_nxt;
      opb1_r <= opb1_nxt;
      sel1_r <= sel1_nxt;
    end
  end

  // Delta, and the hue difference split into magnitude and sign.
  always_comb begin
    delta2_nxt = mx1_r - mn1_r;
    neg2_nxt   = (opa1_r < opb1_r);
    mag2_nxt   = neg2_nxt ? (opb1_r - opa1_r) : (opa1_r - opb1_r);
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      delta2_r <= delta2_nxt;
      mag2_r   <= mag2_nxt;
      neg2_r   <= neg2_nxt;
      mx2_r    <= mx1_r;
      sel2_r   <= sel1_r;
    end
  end

  // Dividends: delta * 65535 for saturation, |diff| * 60 * 2^F for hue.
  always_comb begin
    num_sat_nxt   = (W'(delta2_r) << SAT_W) - W'(delta2_r);
    num_hue_nxt   = W'(mag2_r) * HUE_MUL;
    side_nxt.sel  = sel2_r;
    side_nxt.neg  = neg2_r;
    side_nxt.gray = (delta2_r == '0);
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      num_sat_r <= num_sat_nxt;
      num_hue_r <= num_hue_nxt;
      den_sat_r <= mx2_r;
      den_hue_r <= delta2_r;
      side_r    <= side_nxt;
    end
  end

  assign num_sat = num_sat_r;
  assign den_sat = den_sat_r;
  assign num_hue = num_hue_r;
  assign den_hue = den_hue_r;
  assign side    = side_r;

endmodule

@@ hdl/rhc_div.sv @@
// ============================================================================
// RGB to HSV divider pipeline
// Two restoring dividers in lockstep, one quotient bit per register stage.
// Lane A divides for saturation, lane B for hue; side data rides along.
// ============================================================================
module rhc_div #(
  parameter int CHANNEL_BITS = rhc_pkg::CHANNEL_BITS_DEF,
  parameter int DIV_STEPS    = rhc_pkg::SAT_W
) (
  input  logic                              clk,
  input  logic [DIV_STEPS-1:0]              ld,
  input  logic [CHANNEL_BITS+DIV_STEPS-1:0] num_a,
  input  logic [CHANNEL_BITS-1:0]           den_a,
  input  logic [CHANNEL_BITS+DIV_STEPS-1:0] num_b,
  input  logic [CHANNEL_BITS-1:0]           den_b,
  input  rhc_pkg::hue_side_t                side_in,
  output logic [DIV_STEPS-1:0]              quo_a,
  output logic [CHANNEL_BITS-1:0]           den_a_out,
  output logic [DIV_STEPS-1:0]              quo_b,
  output rhc_pkg::hue_side_t                side_out
);
  import rhc_pkg::*;

  localparam int CB = CHANNEL_BITS;
  localparam int Q  = DIV_STEPS;

  // Per-stage registers of both lanes.
  logic [CB-1:0] rem_a_r [Q];
  logic [CB-1:0] rem_b_r [Q];
  logic [Q-1:0]  lo_a_r  [Q];
  logic [Q-1:0]  lo_b_r  [Q];
  logic [Q-1:0]  quo_a_r [Q];
  logic [Q-1:0]  quo_b_r [Q];
  logic [CB-1:0] den_a_r [Q];
  logic [CB-1:0] den_b_r [Q];
  hue_side_t     side_r  [Q];

  // One compare-and-subtract step. The partial remainder is below the divisor,
  // so after a subtraction it fits the channel width again.
  function automatic logic [CB:0] div_step(input logic [CB-1:0] rem, input logic nb,
                                           input logic [CB-1:0] den);
    logic [CB:0] t;
    logic [CB:0] d;
    t = {rem, nb};
    d = {1'b0, den};
    if (t >= d) begin
      return {CB'(t - d), 1'b1};
    end else begin
      return {CB'(t), 1'b0};
    end
  endfunction

  for (genvar j = 0; j < Q; j++) begin : g_stage
    logic [CB-1:0] rem_a, rem_b, dn_a, dn_b;
    logic [Q-1:0]  lo_a, lo_b, qa, qb;
    hue_side_t     sd;
    logic [CB:0]   step_a_nxt, step_b_nxt;

    // The first stage takes the top bits of the dividend as its remainder.
    if (j == 0) begin : g_first
      assign rem_a = num_a[CB+Q-1:Q];
      assign rem_b = num_b[CB+Q-1:Q];
      assign lo_a  = num_a[Q-1:0];
      assign lo_b  = num_b[Q-1:0];
      assign qa    = '0;
      assign qb    = '0;
      assign dn_a  = den_a;
      assign dn_b  = den_b;
      assign sd    = side_in;
    end else begin : g_next
      assign rem_a = rem_a_r[j-1];
      assign rem_b = rem_b_r[j-1];
      assign lo_a  = lo_a_r[j-1];
      assign lo_b  = lo_b_r[j-1];
      assign qa    = quo_a_r[j-1];
      assign qb    = quo_b_r[j-1];
      assign dn_a  = den_a_r[j-1];
      assign dn_b  = den_b_r[j-1];
      assign sd    = side_r[j-1];
    end

    assign step_a_nxt = div_step(rem_a, lo_a[Q-1], dn_a);
    assign step_b_nxt = div_step(rem_b, lo_b[Q-1], dn_b);

    always_ff @(posedge clk) begin
      if (ld[j]) begin
        rem_a_r[j] <= step_a_nxt[CB:1];
        rem_b_r[j] <= step_b_nxt[CB:1];
        lo_a_r[j]  <= lo_a << 1;
        lo_b_r[j]  <= lo_b << 1;
        quo_a_r[j] <= {qa[Q-2:0], step_a_nxt[0]};
        quo_b_r[j] <= {qb[Q-2:0], step_b_nxt[0]};
        den_a_r[j] <= dn_a;
        den_b_r[j] <= dn_b;
        side_r[j]  <= sd;
      end
    end
  end

  assign quo_a     = quo_a_r[Q-1];
  assign quo_b     = quo_b_r[Q-1];
  assign den_a_out = den_a_r[Q-1];
  assign side_out  = side_r[Q-1];

endmodule

@@ hdl/rhc_back.sv @@
// ============================================================================
// RGB to HSV back end
// Adds the sextant offset to the signed hue fraction, wraps negative hues,
// zeroes gray pixels' hue and saturation and holds the result in a register.
// ============================================================================
module rhc_back #(
  parameter int CHANNEL_BITS      = rhc_pkg::CHANNEL_BITS_DEF,
  parameter int HUE_FRACTION_BITS = rhc_pkg::HUE_FRAC_BITS_DEF,
  parameter int DIV_STEPS         = rhc_pkg::SAT_W
) (
  input  logic                      clk,
  input  logic                      ld,
  input  logic [DIV_STEPS-1:0]      quo_sat,
  input  logic [DIV_STEPS-1:0]      quo_hue,
  input  logic [CHANNEL_BITS-1:0]   value,
  input  rhc_pkg::hue_side_t        side,
  output logic [rhc_pkg::HUE_W-1:0] hue_out,
  output logic [rhc_pkg::SAT_W-1:0] sat_out,
  output logic [CHANNEL_BITS-1:0]   value_out
);
  import rhc_pkg::*;

  // 300 degrees plus sign at the chosen fraction fits in HS bits.
  localparam int HS = HUE_FRACTION_BITS + 11;
  localparam logic signed [HS-1:0] GREEN_S = HS'(GREEN_BASE_DEG) <<< HUE_FRACTION_BITS;
  localparam logic signed [HS-1:0] BLUE_S  = HS'(BLUE_BASE_DEG) <<< HUE_FRACTION_BITS;
  localparam logic signed [HS-1:0] FULL_S  = HS'(FULL_DEG) <<< HUE_FRACTION_BITS;

  logic signed [HS-1:0]   mag_s, base_s, sum_s, wrap_s;
  logic [HUE_W-1:0]       hue_nxt;
  logic [SAT_W-1:0]       sat_nxt;
  logic [HUE_W-1:0]       hue_r;
  logic [SAT_W-1:0]       sat_r;
  logic [CHANNEL_BITS-1:0] value_r;

  // Sextant offset plus the fraction, wrapped into one full turn.
  always_comb begin
    mag_s = $signed(HS'(quo_hue));
    case (side.sel)
      SEL_RED:   base_s = '0;
      SEL_GREEN: base_s = GREEN_S;
      SEL_BLUE:  base_s = BLUE_S;
      default:   base_s = '0;
    endcase
    sum_s   = side.neg ? (base_s - mag_s) : (base_s + mag_s);
    wrap_s  = (sum_s < 0) ? (sum_s + FULL_S) : sum_s;
    hue_nxt = side.gray ? '0 : HUE_W'($unsigned(wrap_s));
    sat_nxt = side.gray ? '0 : quo_sat[SAT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      hue_r   <= hue_nxt;
      sat_r   <= sat_nxt;
      value_r <= value;
    end
  end

  assign hue_out   = hue_r;
  assign sat_out   = sat_r;
  assign value_out = value_r;

endmodule

@@ hdl/rgb_to_hsv_converter.sv @@
// ============================================================================
// RGB to HSV converter
// Streaming colour space conversion, one pixel per clock while the output is not stalled.
// ============================================================================
// Usage: pixels arrive as beats on in_pix (red, green, blue, each
// CHANNEL_BITS wide) and leave as beats on out_hsv (hue in 1/2^F degree
// units, 16-bit saturation, value equal to the largest channel). A beat moves
// when valid and ready are both high at a rising edge of clk.
// The pipeline has DIV_STEPS + 4 register stages, where DIV_STEPS is the
// larger of 16 and HUE_FRACTION_BITS + 6: three front stages, one stage per
// quotient bit of the two restoring dividers, and the output register.
// An accepted pixel moves through the front stages, the divider stages and the
// output register in order. Throughput is one pixel per cycle when unstalled.
// Each stage has its own valid bit and takes a new beat whenever it is empty
// or its successor moves on, so bubbles close up under back-pressure. When
// the receiver stalls, in_pix.ready stays high until every stage is full.
// The synchronous active-low reset clears all valid bits; the datapath is not
// reset. The parameters must match those of the connected interfaces.
// ============================================================================
module rgb_to_hsv_converter #(
  parameter int CHANNEL_BITS      = rhc_pkg::CHANNEL_BITS_DEF,
  parameter int HUE_FRACTION_BITS = rhc_pkg::HUE_FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  rhc_pixel_if.sink  in_pix,
  rhc_hsv_if.source  out_hsv
);
  import rhc_pkg::*;

  localparam int DIV_STEPS = (HUE_FRACTION_BITS + 6 > SAT_W) ? (HUE_FRACTION_BITS + 6) : SAT_W;
  localparam int NSTG      = DIV_STEPS + 4;
  localparam int CB        = CHANNEL_BITS;
  localparam int W         = CHANNEL_BITS + DIV_STEPS;

  logic [NSTG-1:0] vld_r, vld_nxt, vld_in, rdy, ld;

  logic [W-1:0]     num_sat, num_hue;
  logic [CB-1:0]    den_sat, den_hue, value_d;
  logic [DIV_STEPS-1:0] quo_sat, quo_hue;
  hue_side_t        side_f, side_d;

  // A stage may load when it or any stage after it is empty, or the output moves.
  for (genvar k = 0; k < NSTG; k++) begin : g_rdy
    assign rdy[k] = out_hsv.ready || !(&vld_r[NSTG-1:k]);
  end

  // Valid bits travel one stage per load.
  always_comb begin
    vld_in  = {vld_r[NSTG-2:0], in_pix.valid};
    ld      = rdy & vld_in;
    vld_nxt = (rdy & vld_in) | (~rdy & vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_pix.ready  = rdy[0];
  assign out_hsv.valid = vld_r[NSTG-1];

  // Max/min search, differences and dividends.
  rhc_front #(
    .CHANNEL_BITS      (CHANNEL_BITS),
    .HUE_FRACTION_BITS (HUE_FRACTION_BITS),
    .DIV_STEPS         (DIV_STEPS)
  ) u_front (
    .clk     (clk),
    .ld      (ld[2:0]),
    .red     (in_pix.red_in),
    .green   (in_pix.green_in),
    .blue    (in_pix.blue_in),
    .num_sat (num_sat),
    .den_sat (den_sat),
    .num_hue (num_hue),
    .den_hue (den_hue),
    .side    (side_f)
  );

  // Saturation and hue divisions; the saturation divisor is the value.
  rhc_div #(
    .CHANNEL_BITS (CHANNEL_BITS),
    .DIV_STEPS    (DIV_STEPS)
  ) u_div (
    .clk       (clk),
    .ld        (ld[DIV_STEPS+2:3]),
    .num_a     (num_sat),
    .den_a     (den_sat),
    .num_b     (num_hue),
    .den_b     (den_hue),
    .side_in   (side_f),
    .quo_a     (quo_sat),
    .den_a_out (value_d),
    .quo_b     (quo_hue),
    .side_out  (side_d)
  );

  // Hue assembly and output register.
  rhc_back #(
    .CHANNEL_BITS      (CHANNEL_BITS),
    .HUE_FRACTION_BITS (HUE_FRACTION_BITS),
    .DIV_STEPS         (DIV_STEPS)
  ) u_back (
    .clk       (clk),
    .ld        (ld[NSTG-1]),
    .quo_sat   (quo_sat),
    .quo_hue   (quo_hue),
    .value     (value_d),
    .side      (side_d),
    .hue_out   (out_hsv.hue_out),
    .sat_out   (out_hsv.sat_out),
    .value_out (out_hsv.value_out)
  );

  // The pipeline is empty after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_hsv.valid)
    else $error("result beat presented straight after reset");

  // Input back-pressure only arises when every stage is full and the output stalls.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_pix.ready |-> (out_hsv.valid && !out_hsv.ready))
    else $error("input stalled while the pipeline has room");

  // Zero saturation only comes from a gray pixel, whose hue is zero.
  a_gray_hue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_hsv.valid && out_hsv.sat_out == '0) |-> (out_hsv.hue_out == '0))
    else $error("unsaturated pixel with non-zero hue");

  // A black pixel has no saturation.
  a_black_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_hsv.valid && out_hsv.value_out == '0) |-> (out_hsv.sat_out == '0))
    else $error("black pixel with non-zero saturation");

  // Hue stays below a full turn whenever a full turn fits the hue field.
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_hsv.valid |-> ((HUE_FRACTION_BITS > 6) ||
                       (out_hsv.hue_out < HUE_W'(FULL_DEG << HUE_FRACTION_BITS))))
    else $error("hue outside one full turn");

endmodule
